@@ rtl/core/srpt_pkg.sv @@
// ----------------------------------------------------------------------------
// srpt_pkg
// Shared types, widths and codes for the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srpt_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int REM_W       = 32;
   localparam int TIME_W      = 48;

   localparam logic MODE_ARRIVAL  = 1'b0;
   localparam logic MODE_COMPLETE = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_NO_JOB = 2'd2;

   typedef struct packed {
      logic               mode;
      logic [ID_W-1:0]    job_id;
      logic [REM_W-1:0]   service_time;
      logic [TIME_W-1:0]  now;
   } req_type;

   typedef struct packed {
      logic               cancel_previous;
      logic               schedule_valid;
      logic [TIME_W-1:0]  completion_time;
      logic [ID_W-1:0]    running_id;
      logic               completed_valid;
      logic [ID_W-1:0]    completed_id;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [REM_W-1:0]   remaining;
   } entry_type;

   typedef struct packed {
      logic               rd_en;
      logic [SLOT_W-1:0]  rd_addr;
      logic               wr_en;
      logic               set_en;
      logic [SLOT_W-1:0]  wr_addr;
      entry_type          wr_data;
      logic               clr_en;
      logic [SLOT_W-1:0]  clr_slot;
   } tbl_ctl_type;

   // ordering key: remaining time first, then id
   function automatic logic key_less(input logic [REM_W-1:0] rem_a,
                                     input logic [ID_W-1:0]  id_a,
                                     input logic [REM_W-1:0] rem_b,
                                     input logic [ID_W-1:0]  id_b);
      logic lt;
      lt = (rem_a < rem_b) || ((rem_a == rem_b) && (id_a < id_b));
      return lt;
   endfunction

endpackage

@@ rtl/core/srpt_table.sv @@
// ----------------------------------------------------------------------------
// srpt_table
// Job table: id and remaining time in a synchronous memory, occupancy in flops.
// ----------------------------------------------------------------------------
module srpt_table (
   input  logic                                   clock,
   input  logic                                   reset,
   input  srpt_pkg::tbl_ctl_type                  ctl,
   output srpt_pkg::entry_type                    rd_data,
   output logic [srpt_pkg::QUEUE_DEPTH-1:0]       valid
);

   srpt_pkg::entry_type                  mem [srpt_pkg::QUEUE_DEPTH];
   srpt_pkg::entry_type                  rd_data_ff;
   logic [srpt_pkg::QUEUE_DEPTH-1:0]     valid_ff;
   logic [srpt_pkg::QUEUE_DEPTH-1:0]     valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.set_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
      if (ctl.clr_en) begin
         valid_in[ctl.clr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule

@@ rtl/core/srpt_sched.sv @@
// ----------------------------------------------------------------------------
// srpt_sched
// Event sequencer: scans the job table, ages the running job, inserts
// arrivals, retires completions and picks the next job to run.
// ----------------------------------------------------------------------------
module srpt_sched (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  srpt_pkg::req_type                      req_payload,
   output srpt_pkg::tbl_ctl_type                  tbl_ctl,
   input  srpt_pkg::entry_type                    tbl_rd_data,
   input  logic [srpt_pkg::QUEUE_DEPTH-1:0]       tbl_valid,
   input  logic                                   out_free,
   output logic                                   res_valid,
   output srpt_pkg::rsp_type                      res
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PREP = 6'b000010,
      S_SCAN = 6'b000100,
      S_WRUN = 6'b001000,
      S_WNEW = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   localparam logic [srpt_pkg::SLOT_W-1:0] LAST_SLOT =
      srpt_pkg::SLOT_W'(srpt_pkg::QUEUE_DEPTH - 1);
   localparam logic [srpt_pkg::CNT_W-1:0]  CNT_END =
      srpt_pkg::CNT_W'(srpt_pkg::QUEUE_DEPTH);

   state_type                          state_ff, state_in;
   srpt_pkg::req_type                  req_ff, req_in;
   logic                               run_ff, run_in;
   logic [srpt_pkg::SLOT_W-1:0]        run_slot_ff, run_slot_in;
   logic [srpt_pkg::TIME_W-1:0]        start_ff, start_in;
   logic [srpt_pkg::TIME_W-1:0]        elapsed_ff, elapsed_in;
   logic [srpt_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                               pv_ff, pv_in;
   logic [srpt_pkg::SLOT_W-1:0]        pslot_ff, pslot_in;
   logic                               best_found_ff, best_found_in;
   logic [srpt_pkg::REM_W-1:0]         best_rem_ff, best_rem_in;
   logic [srpt_pkg::ID_W-1:0]          best_id_ff, best_id_in;
   logic [srpt_pkg::SLOT_W-1:0]        best_slot_ff, best_slot_in;
   logic                               free_found_ff, free_found_in;
   logic [srpt_pkg::SLOT_W-1:0]        free_slot_ff, free_slot_in;
   logic [srpt_pkg::REM_W-1:0]         run_rem_ff, run_rem_in;
   logic [srpt_pkg::ID_W-1:0]          run_id_ff, run_id_in;

   logic                               arrival;
   logic                               run_hit;
   logic [srpt_pkg::REM_W-1:0]         adj_rem;
   logic [srpt_pkg::REM_W-1:0]         cand_rem;
   logic                               new_wins;
   logic [srpt_pkg::TIME_W:0]          done_sum;
   logic [srpt_pkg::TIME_W-1:0]        done_time;
   logic                               ev_ok;

   assign arrival = (req_ff.mode == srpt_pkg::MODE_ARRIVAL);
   assign run_hit = pv_ff && run_ff && (pslot_ff == run_slot_ff);

   // running job aged by the elapsed time, floored at zero
   assign adj_rem = (elapsed_ff >= srpt_pkg::TIME_W'(tbl_rd_data.remaining)) ? '0 :
                    tbl_rd_data.remaining - elapsed_ff[srpt_pkg::REM_W-1:0];
   assign cand_rem = (arrival && run_hit) ? adj_rem : tbl_rd_data.remaining;

   // new entry sits at the free slot; lower slot wins a full tie
   assign new_wins = !best_found_ff ||
      srpt_pkg::key_less(req_ff.service_time, req_ff.job_id, best_rem_ff, best_id_ff) ||
      ((req_ff.service_time == best_rem_ff) && (req_ff.job_id == best_id_ff) &&
       (free_slot_ff < best_slot_ff));

   assign done_sum  = {1'b0, req_ff.now} + (srpt_pkg::TIME_W + 1)'(best_rem_ff);
   assign done_time = done_sum[srpt_pkg::TIME_W] ? '1 : done_sum[srpt_pkg::TIME_W-1:0];

   assign ev_ok = arrival ? free_found_ff : run_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      run_in        = run_ff;
      run_slot_in   = run_slot_ff;
      start_in      = start_ff;
      elapsed_in    = elapsed_ff;
      cnt_in        = cnt_ff;
      pv_in         = pv_ff;
      pslot_in      = pslot_ff;
      best_found_in = best_found_ff;
      best_rem_in   = best_rem_ff;
      best_id_in    = best_id_ff;
      best_slot_in  = best_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      run_rem_in    = run_rem_ff;
      run_id_in     = run_id_ff;
      tbl_ctl       = '0;
      res           = '0;
      res_valid     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               run_in        = run_ff && tbl_valid[run_slot_ff];
               cnt_in        = '0;
               pv_in         = 1'b0;
               best_found_in = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_PREP;
            end
         end
         S_PREP: begin
            elapsed_in = (req_ff.now >= start_ff) ? req_ff.now - start_ff : '0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            // issue one read a cycle, compare the data in the next cycle
            if (cnt_ff != CNT_END) begin
               tbl_ctl.rd_en   = 1'b1;
               tbl_ctl.rd_addr = cnt_ff[srpt_pkg::SLOT_W-1:0];
               cnt_in          = cnt_ff + 1'b1;
               pv_in           = 1'b1;
               pslot_in        = cnt_ff[srpt_pkg::SLOT_W-1:0];
            end else begin
               pv_in = 1'b0;
            end
            if (pv_ff) begin
               if (run_hit) begin
                  run_id_in  = tbl_rd_data.id;
                  run_rem_in = adj_rem;
               end
               if (!tbl_valid[pslot_ff]) begin
                  if (!free_found_ff) begin
                     free_found_in = 1'b1;
                     free_slot_in  = pslot_ff;
                  end
               end else if (arrival || !run_hit) begin
                  if (!best_found_ff ||
                      srpt_pkg::key_less(cand_rem, tbl_rd_data.id, best_rem_ff, best_id_ff)) begin
                     best_found_in = 1'b1;
                     best_rem_in   = cand_rem;
                     best_id_in    = tbl_rd_data.id;
                     best_slot_in  = pslot_ff;
                  end
               end
               if (pslot_ff == LAST_SLOT) begin
                  state_in = arrival ? S_WRUN : S_FIN;
               end
            end
         end
         S_WRUN: begin
            if (!free_found_ff) begin
               state_in = S_FIN;
            end else begin
               if (run_ff) begin
                  tbl_ctl.wr_en             = 1'b1;
                  tbl_ctl.wr_addr           = run_slot_ff;
                  tbl_ctl.wr_data.id        = run_id_ff;
                  tbl_ctl.wr_data.remaining = run_rem_ff;
               end
               state_in = S_WNEW;
            end
         end
         S_WNEW: begin
            tbl_ctl.wr_en             = 1'b1;
            tbl_ctl.set_en            = 1'b1;
            tbl_ctl.wr_addr           = free_slot_ff;
            tbl_ctl.wr_data.id        = req_ff.job_id;
            tbl_ctl.wr_data.remaining = req_ff.service_time;
            if (new_wins) begin
               best_found_in = 1'b1;
               best_rem_in   = req_ff.service_time;
               best_id_in    = req_ff.job_id;
               best_slot_in  = free_slot_ff;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!ev_ok) begin
               res.status = arrival ? srpt_pkg::STATUS_FULL : srpt_pkg::STATUS_NO_JOB;
            end else begin
               res.status          = srpt_pkg::STATUS_OK;
               res.cancel_previous = arrival && run_ff;
               res.completed_valid = !arrival;
               res.completed_id    = arrival ? '0 : run_id_ff;
               res.schedule_valid  = best_found_ff;
               res.completion_time = best_found_ff ? done_time : '0;
               res.running_id      = best_found_ff ? best_id_ff : '0;
            end
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
               if (ev_ok) begin
                  if (!arrival) begin
                     tbl_ctl.clr_en   = 1'b1;
                     tbl_ctl.clr_slot = run_slot_ff;
                  end
                  run_in = best_found_ff;
                  if (best_found_ff) begin
                     run_slot_in = best_slot_ff;
                     start_in    = req_ff.now;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         run_ff      <= 1'b0;
         run_slot_ff <= '0;
         start_ff    <= '0;
         cnt_ff      <= '0;
         pv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         run_ff      <= run_in;
         run_slot_ff <= run_slot_in;
         start_ff    <= start_in;
         cnt_ff      <= cnt_in;
         pv_ff       <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      elapsed_ff    <= elapsed_in;
      pslot_ff      <= pslot_in;
      best_found_ff <= best_found_in;
      best_rem_ff   <= best_rem_in;
      best_id_ff    <= best_id_in;
      best_slot_ff  <= best_slot_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      run_rem_ff    <= run_rem_in;
      run_id_ff     <= run_id_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_END)
      else $error("scan counter past table depth");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status == srpt_pkg::STATUS_FULL) |-> (&tbl_valid))
      else $error("arrival dropped with a free slot");

   a_sched_runs: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.schedule_valid |=> run_ff && tbl_valid[run_slot_ff])
      else $error("scheduled job not marked running");

   a_done_cleared: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.completed_valid |=> !tbl_valid[$past(run_slot_ff)])
      else $error("completed job still in table");

endmodule

@@ rtl/core/srpt_preemptive_scheduler.sv @@
// ----------------------------------------------------------------------------
// srpt_preemptive_scheduler
// Preemptive shortest-remaining-time scheduler with a 32-entry job table.
//
//   channel  direction  handshake              beat contents
//   req      in         req_valid / req_ready  req_payload (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_payload (rsp_type)
//
// An event steps through a setup state, a scan that issues one table read a cycle
// through the single memory read port and then drains it, up to two write-backs
// on an arrival, and a result state.
// Synchronous reset empties the table at once through its occupancy flops.
// A finished result waits in the output register; the next event is taken
// meanwhile and stalls in its final cycle only while that register is full.
// ----------------------------------------------------------------------------
module srpt_preemptive_scheduler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  srpt_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srpt_pkg::rsp_type    rsp_payload
);

   srpt_pkg::tbl_ctl_type                tbl_ctl;
   srpt_pkg::entry_type                  tbl_rd_data;
   logic [srpt_pkg::QUEUE_DEPTH-1:0]     tbl_valid;
   logic                                 out_free;
   logic                                 res_valid;
   srpt_pkg::rsp_type                    res;

   logic                                 rsp_valid_ff, rsp_valid_in;
   srpt_pkg::rsp_type                    rsp_payload_ff, rsp_payload_in;

   srpt_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .rd_data (tbl_rd_data),
      .valid   (tbl_valid)
   );

   srpt_sched u_sched (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .tbl_ctl     (tbl_ctl),
      .tbl_rd_data (tbl_rd_data),
      .tbl_valid   (tbl_valid),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res)
   );

   // output register frees up in the same cycle its beat is taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_payload_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ verif/tb_srpt_preemptive_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_srpt_preemptive_scheduler
// Self-checking bench for the shortest-remaining-time scheduler. A directed
// run covers idle completions, ties, zero service, duplicate ids, time going
// backwards and saturation; random bursts then fill and drain the job table.
// Every result beat is checked field by field against an in-bench scheduler
// model, under shifting req/rsp idle patterns.
// ----------------------------------------------------------------------------
module tb_srpt_preemptive_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [srpt_pkg::TIME_W-1:0] TIME_MAX = '1;
   localparam int                RANDOM_EVENTS = 1400;
   localparam int                REPORT_LIMIT  = 10;

   typedef struct {
      srpt_pkg::req_type beat;
      bit      quiesce;   // hold this beat until no decision is outstanding
   } job_event_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   srpt_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   srpt_pkg::rsp_type rsp_payload;

   job_event_type     event_queue[$];
   srpt_pkg::rsp_type pending_decisions[$];
   srpt_pkg::rsp_type observed_want;
   int            total_events;
   int            accepted_count = 0;
   int            fault_count    = 0;
   logic [1:0]    idle_phase     = 2'd0;

   // scheduler state as the bench sees it
   logic                        slot_live [srpt_pkg::QUEUE_DEPTH];
   logic [srpt_pkg::ID_W-1:0]   slot_job  [srpt_pkg::QUEUE_DEPTH];
   logic [srpt_pkg::REM_W-1:0]  slot_left [srpt_pkg::QUEUE_DEPTH];
   logic                        cpu_busy  = 1'b0;
   logic [srpt_pkg::SLOT_W-1:0] run_slot  = '0;
   logic [srpt_pkg::TIME_W-1:0] run_since = '0;

   srpt_preemptive_scheduler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < srpt_pkg::QUEUE_DEPTH; i++) begin
         slot_live[i] = 1'b0;
         slot_job[i]  = '0;
         slot_left[i] = '0;
      end
   end

   // applies one event to the bench state and returns the decision it causes
   function automatic srpt_pkg::rsp_type schedule_event(input srpt_pkg::req_type ev);
      srpt_pkg::rsp_type           decision;
      int                          free_slot;
      int                          best;
      logic [srpt_pkg::TIME_W-1:0] elapsed;
      logic [srpt_pkg::TIME_W:0]   finish;
      decision = '0;
      if (!slot_live[run_slot]) cpu_busy = 1'b0;
      if (ev.mode == srpt_pkg::MODE_ARRIVAL) begin
         free_slot = -1;
         for (int i = srpt_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_live[i]) free_slot = i;
         end
         if (free_slot < 0) begin
            decision.status = srpt_pkg::STATUS_FULL;
            return decision;
         end
         if (cpu_busy) begin
            elapsed = (ev.now >= run_since) ? ev.now - run_since : '0;
            if (elapsed >= srpt_pkg::TIME_W'(slot_left[run_slot]))
               slot_left[run_slot] = '0;
            else
               slot_left[run_slot] = slot_left[run_slot] - elapsed[srpt_pkg::REM_W-1:0];
            decision.cancel_previous = 1'b1;
         end
         slot_live[free_slot] = 1'b1;
         slot_job[free_slot]  = ev.job_id;
         slot_left[free_slot] = ev.service_time;
      end else begin
         if (!cpu_busy) begin
            decision.status = srpt_pkg::STATUS_NO_JOB;
            return decision;
         end
         decision.completed_valid = 1'b1;
         decision.completed_id    = slot_job[run_slot];
         slot_live[run_slot] = 1'b0;
         cpu_busy = 1'b0;
      end
      // shortest remaining first, lower id on ties, lower slot after that
      best = -1;
      for (int i = 0; i < srpt_pkg::QUEUE_DEPTH; i++) begin
         if (slot_live[i]) begin
            if (best < 0) begin
               best = i;
            end else if (slot_left[i] < slot_left[best] ||
                         (slot_left[i] == slot_left[best] &&
                          slot_job[i] < slot_job[best])) begin
               best = i;
            end
         end
      end
      if (best >= 0) begin
         finish = {1'b0, ev.now} + (srpt_pkg::TIME_W + 1)'(slot_left[best]);
         cpu_busy  = 1'b1;
         run_slot  = best[srpt_pkg::SLOT_W-1:0];
         run_since = ev.now;
         decision.schedule_valid  = 1'b1;
         decision.completion_time = finish[srpt_pkg::TIME_W] ? TIME_MAX :
                                    finish[srpt_pkg::TIME_W-1:0];
         decision.running_id      = slot_job[best];
      end
      return decision;
   endfunction

   task automatic add_event(input logic mode, input logic [srpt_pkg::ID_W-1:0] id,
                            input logic [srpt_pkg::REM_W-1:0] svc,
                            input logic [srpt_pkg::TIME_W-1:0] at,
                            input bit quiesce);
      job_event_type ev;
      ev.beat.mode         = mode;
      ev.beat.job_id       = id;
      ev.beat.service_time = svc;
      ev.beat.now          = at;
      ev.quiesce           = quiesce;
      event_queue.push_back(ev);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pending_decisions.push_back(schedule_event(req_payload));
            accepted_count++;
         end
         idle_phase <= (accepted_count < total_events / 3)     ? 2'd0 :
                       (accepted_count < 2 * total_events / 3) ? 2'd1 : 2'd2;
         if (!req_valid || req_ready) begin
            if (event_queue.size() != 0 &&
                !(event_queue[0].quiesce && pending_decisions.size() != 0) &&
                $urandom_range(99) >= ((idle_phase == 2'd0) ? 9 :
                                       (idle_phase == 2'd1) ? 85 : 0)) begin
               req_valid   <= 1'b1;
               req_payload <= event_queue[0].beat;
               void'(event_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_decisions.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("result beat with nothing expected: %p", rsp_payload);
            end else begin
               observed_want = pending_decisions.pop_front();
               check_field("cancel_previous", 64'(observed_want.cancel_previous),
                           64'(rsp_payload.cancel_previous));
               check_field("schedule_valid", 64'(observed_want.schedule_valid),
                           64'(rsp_payload.schedule_valid));
               check_field("completion_time", 64'(observed_want.completion_time),
                           64'(rsp_payload.completion_time));
               check_field("running_id", 64'(observed_want.running_id),
                           64'(rsp_payload.running_id));
               check_field("completed_valid", 64'(observed_want.completed_valid),
                           64'(rsp_payload.completed_valid));
               check_field("completed_id", 64'(observed_want.completed_id),
                           64'(rsp_payload.completed_id));
               check_field("status", 64'(observed_want.status), 64'(rsp_payload.status));
            end
         end
         rsp_ready <= ($urandom_range(99) >= ((idle_phase == 2'd0) ? 85 :
                                              (idle_phase == 2'd1) ? 9 : 0));
      end
   end

   initial begin
      logic [srpt_pkg::TIME_W-1:0] t;
      logic [63:0]                 wide;
      logic [srpt_pkg::ID_W-1:0]   id;
      logic [srpt_pkg::REM_W-1:0]  svc;
      logic                        mode;
      int                random_count;
      int                chunk_no;
      int                chunk_len;
      int                arrival_pct;
      int                pick;

      // directed events
      add_event(srpt_pkg::MODE_COMPLETE, 16'h0000, 32'h0000_0000, 48'd0, 1'b0);  // nothing running
      add_event(srpt_pkg::MODE_ARRIVAL, 16'hFFFF, 32'd100, 48'd10, 1'b0);
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h0000, 32'd100, 48'd10, 1'b0);  // equal remaining
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h0005, 32'd0, 48'd20, 1'b0);    // zero service
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h0005, 32'd0, 48'd20, 1'b0);    // same id again
      add_event(srpt_pkg::MODE_COMPLETE, 16'hFFFF, 32'hFFFF_FFFF, 48'd20, 1'b0);
      add_event(srpt_pkg::MODE_COMPLETE, 16'h0000, 32'h0000_0000, 48'd25, 1'b0);
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h0007, 32'd200, 48'd5, 1'b0);   // clock went back
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h1234, 32'hFFFF_FFFF, TIME_MAX, 1'b0);
      for (int i = 0; i < 5; i++)
         add_event(srpt_pkg::MODE_COMPLETE, 16'hAAAA, 32'h5555_5555, TIME_MAX, 1'b0);
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h8000, 32'hFFFF_FFFF, 48'd0, 1'b0);
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h8001, 32'h8000_0000, 48'h0000_FFFF_FFFF, 1'b0);
      add_event(srpt_pkg::MODE_ARRIVAL, 16'h5555, 32'd3, 48'h8000_0000_0000, 1'b0);
      for (int i = 0; i < 4; i++)
         add_event(srpt_pkg::MODE_COMPLETE, 16'h0000, 32'h0000_0000,
                   48'h8000_0000_0100, 1'b0);

      // random bursts: a table fill and a full drain first, then mixed bursts
      t = '0;
      random_count = 0;
      chunk_no = 0;
      while (random_count < RANDOM_EVENTS) begin
         chunk_len = $urandom_range(20, 60);
         case ($urandom_range(3))
            0:       arrival_pct = 25;
            1:       arrival_pct = 50;
            2:       arrival_pct = 75;
            default: arrival_pct = 95;
         endcase
         if (chunk_no == 0) begin
            chunk_len   = srpt_pkg::QUEUE_DEPTH + 4;
            arrival_pct = 100;
         end else if (chunk_no == 1) begin
            chunk_len   = srpt_pkg::QUEUE_DEPTH + 8;
            arrival_pct = 0;
         end
         for (int k = 0; k < chunk_len; k++) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
               t = t + srpt_pkg::TIME_W'($urandom_range(300));
            end else if (pick < 88) begin
               t = t + srpt_pkg::TIME_W'($urandom_range(1 << 20));
            end else if (pick < 94) begin
               t = t - srpt_pkg::TIME_W'($urandom_range(50));
            end else if (pick < 97) begin
               t = TIME_MAX - srpt_pkg::TIME_W'($urandom_range(1000));
            end else begin
               wide = {$urandom, $urandom};
               t = wide[srpt_pkg::TIME_W-1:0];
            end
            pick = $urandom_range(99);
            if (pick < 60)      svc = $urandom_range(400);
            else if (pick < 75) svc = $urandom_range(3);
            else if (pick < 90) svc = $urandom;
            else if (pick < 95) svc = '0;
            else                svc = '1;
            id = ($urandom_range(99) < 70) ? srpt_pkg::ID_W'($urandom) :
                                             srpt_pkg::ID_W'($urandom_range(7));
            mode = ($urandom_range(99) < arrival_pct) ? srpt_pkg::MODE_ARRIVAL :
                                                        srpt_pkg::MODE_COMPLETE;
            add_event(mode, id, svc, t,
                      (random_count == 0) || ($urandom_range(199) == 0));
            random_count++;
         end
         chunk_no++;
      end
      total_events = event_queue.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (event_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fault_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
